>>> hdl/seconds_to_calendar_assert.svh
// Assertion shorthands for the calendar converter. Each use names its own
// label; clk_i and rst_ni of the including module clock and disable them.
`ifndef SECONDS_TO_CALENDAR_ASSERT_SVH
`define SECONDS_TO_CALENDAR_ASSERT_SVH

// Same-cycle implication.
`define S2C_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define S2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/s2c_pkg.sv
package s2c_pkg;

  localparam logic [16:0] SecsPerDay      = 17'd86400;
  localparam logic [15:0] ZoneOffsetReset = 16'd28800;

  // floor(2^35 / 675); seconds / 86400 == (seconds >> 7) / 675
  localparam logic [25:0] DayRecip       = 26'd50903316;
  localparam int unsigned DayRecipShift  = 35;
  // floor(2^32 / 365.2425), applied to days + 1
  localparam logic [23:0] YearRecip      = 24'd11759221;
  localparam int unsigned YearRecipShift = 32;
  // ceil(2^19 / 7)
  localparam logic [16:0] WeekRecip      = 17'd74899;
  localparam int unsigned WeekRecipShift = 19;
  // ceil(2^20 / 225); seconds / 3600 == (seconds >> 4) / 225
  localparam logic [12:0] HourRecip      = 13'd4661;
  localparam int unsigned HourRecipShift = 20;
  // ceil(2^14 / 15); seconds / 60 == (seconds >> 2) / 15
  localparam logic [10:0] MinRecip       = 11'd1093;
  localparam int unsigned MinRecipShift  = 14;

  localparam logic [11:0] SecsPerHour    = 12'd3600;
  localparam logic [5:0]  SecsPerMin     = 6'd60;
  localparam logic [8:0]  DaysPerYear    = 9'd365;
  localparam logic [2:0]  DaysPerWeek    = 3'd7;
  localparam logic [2:0]  WeekdayAtEpoch = 3'd6;   // 2000-01-01 is a Saturday
  localparam logic [7:0]  YearBase       = 8'd100; // 2000 - 1900
  localparam logic [7:0]  CenturyYear    = 8'd100; // 2100, not a leap year
  localparam logic [3:0]  NumMonths      = 4'd12;
  localparam logic [3:0]  March          = 4'd2;

  // First day of year of each month in a common year.
  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic s8;
    logic s7;
    logic s6;
    logic s5;
  } tod_en_t;

  // Leap test for year 2000 + y; within 8 bits only 0, 100 and 200 are
  // multiples of 100, and only 0 is a multiple of 400.
  function automatic logic is_leap(logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != CenturyYear) && (y != 8'd200);
  endfunction

  function automatic logic [8:0] month_start(logic [3:0] m, logic leap);
    logic [8:0] s;
    s = 9'd0;
    if (m < NumMonths) begin
      s = MonthStart[m];
    end
    if (leap && (m >= March)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

>>> hdl/s2c_time_of_day.sv
module s2c_time_of_day (
  input  logic              clk_i,
  input  s2c_pkg::tod_en_t  en_i,
  input  logic [16:0]       dsec_i,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o
);
  import s2c_pkg::*;

  logic [25:0] hour_prod;
  logic [16:0] rem_full;
  logic [20:0] min_prod;
  logic [11:0] sec_full;

  logic [16:0] dsec5_q;
  logic [4:0]  hour5_q, hour6_q, hour7_q, hour8_q;
  logic [11:0] rem6_q, rem7_q;
  logic [5:0]  min7_q, min8_q;
  logic [5:0]  sec8_q;

  assign hour_prod = 26'(dsec_i[16:4]) * 26'(HourRecip);
  assign rem_full  = dsec5_q - 17'(hour5_q) * 17'(SecsPerHour);
  assign min_prod  = 21'(rem6_q[11:2]) * 21'(MinRecip);
  assign sec_full  = rem7_q - 12'(min7_q) * 12'(SecsPerMin);

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      hour5_q <= hour_prod[HourRecipShift +: 5];
      dsec5_q <= dsec_i;
    end
    if (en_i.s6) begin
      rem6_q  <= rem_full[11:0];
      hour6_q <= hour5_q;
    end
    if (en_i.s7) begin
      min7_q  <= min_prod[MinRecipShift +: 6];
      rem7_q  <= rem6_q;
      hour7_q <= hour6_q;
    end
    if (en_i.s8) begin
      sec8_q  <= sec_full[5:0];
      min8_q  <= min7_q;
      hour8_q <= hour7_q;
    end
  end

  assign hour_o   = hour8_q;
  assign minute_o = min8_q;
  assign second_o = sec8_q;

endmodule

>>> hdl/seconds_to_calendar.sv
// Seconds-count to calendar converter.
// Input stream (s_axis): one 32-bit count of seconds since 2000-01-01 00:00
// UTC per transfer. Output stream (m_axis): the local date and time of that
// count, one transfer per input, in input order.
// The configured zone offset (cfg_we_i / cfg_wdata_i) is added modulo 2^32
// before conversion; write it only while no transfer is in flight.
// Throughput: one transfer per cycle while the receiver is ready. An input
// transfer reaches m_axis_tvalid_o through the nine register stages (offset add,
// day reciprocal, remainder, day correction, year/weekday/hour reciprocals,
// year start, year correction, month search, day-of-month subtract).
// Each stage holds its item while the stage behind it is full and not advancing; when the
// receiver stalls, the pipe fills and s_axis_tready_o drops after the
// bubbles are used up. Nothing is dropped or repeated.
// Reset empties the pipe and loads the zone offset with 28800 seconds.
`include "seconds_to_calendar_assert.svh"

module seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] seconds_count
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
  // [25:22] month, [33:26] year_since_1900, [36:34] weekday,
  // [45:37] day_of_year, [47:46] zero
  output logic [47:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i      // zone_offset_seconds
);
  import s2c_pkg::*;

  localparam int unsigned NumStages = 9;

  logic [15:0]          zone_q;
  logic [NumStages:1]   v_q;
  logic [NumStages+1:1] en;
  tod_en_t              tod_en;

  // stage payloads
  logic [31:0] t1_q, t2_q;
  logic [15:0] q2_q, q3_q;
  logic [17:0] r3_q;
  logic [15:0] days4_q, days5_q, days6_q;
  logic [16:0] dsec4_q;
  logic [7:0]  y5_q, y6_q;
  logic [12:0] wq5_q;
  logic [15:0] start6_q;
  logic        leap_cur6_q, leap_prev6_q;
  logic [2:0]  wday6_q, wday7_q, wday8_q;
  logic [7:0]  year7_q, year8_q;
  logic [8:0]  yday7_q, yday8_q;
  logic        leap7_q, leap8_q;
  logic [3:0]  month8_q;
  logic [5:0]  sec9_q, min9_q;
  logic [4:0]  hour9_q, dom9_q;
  logic [3:0]  month9_q;
  logic [7:0]  year9_q;
  logic [2:0]  wday9_q;
  logic [8:0]  yday9_q;

  // combinational stage logic
  logic [50:0] day_prod;
  logic [31:0] rem_full;
  logic        over_day;
  logic [40:0] year_prod;
  logic [32:0] week_prod;
  logic [15:0] start_d;
  logic [15:0] wday_full;
  logic        back_year;
  logic [15:0] yday_diff;
  logic [15:0] yday_back;
  logic [3:0]  month_d;
  logic [8:0]  dom_full;
  logic [4:0]  hour8, dom_unused_pad;
  logic [5:0]  min8, sec8;

  // Advance a stage when it is empty or the stage behind it advances.
  always_comb begin
    en[NumStages+1] = m_axis_tready_i;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = v_q[NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= ZoneOffsetReset;
    end else if (cfg_we_i) begin
      zone_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Days estimate may fall one short; the day correction stage repairs it.
  assign day_prod  = 51'(t1_q[31:7]) * 51'(DayRecip);
  assign rem_full  = t2_q - 32'(q2_q) * 32'(SecsPerDay);
  assign over_day  = (r3_q >= 18'(SecsPerDay));

  // Year estimate is the true year or one past it.
  assign year_prod = 41'(17'(days4_q) + 17'd1) * 41'(YearRecip);
  assign week_prod = 33'(days4_q + 16'(WeekdayAtEpoch)) * 33'(WeekRecip);

  // Start day of year y5 (valid for y5 up to 179): leap days before it are
  // (y + 3) / 4, less the skipped one at 2100.
  assign start_d   = 16'(y5_q) * 16'(DaysPerYear) + 16'((9'(y5_q) + 9'd3) >> 2)
                   - 16'(y5_q > CenturyYear);
  assign wday_full = days5_q + 16'(WeekdayAtEpoch) - 16'(wq5_q) * 16'(DaysPerWeek);

  // Step the year back when the estimate overshoots.
  assign back_year = (days6_q < start6_q);
  assign yday_diff = days6_q - start6_q;
  assign yday_back = yday_diff + 16'(DaysPerYear) + 16'(leap_prev6_q);

  always_comb begin
    month_d = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday7_q >= month_start(4'(m), leap7_q)) begin
        month_d = month_d + 4'd1;
      end
    end
  end

  assign dom_full = yday8_q - month_start(month8_q, leap8_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t1_q <= s_axis_tdata_i + 32'(zone_q);
    end
    if (en[2]) begin
      q2_q <= day_prod[DayRecipShift +: 16];
      t2_q <= t1_q;
    end
    if (en[3]) begin
      r3_q <= rem_full[17:0];
      q3_q <= q2_q;
    end
    if (en[4]) begin
      days4_q <= q3_q + 16'(over_day);
      dsec4_q <= over_day ? 17'(r3_q - 18'(SecsPerDay)) : r3_q[16:0];
    end
    if (en[5]) begin
      y5_q    <= year_prod[YearRecipShift +: 8];
      wq5_q   <= week_prod[WeekRecipShift +: 13];
      days5_q <= days4_q;
    end
    if (en[6]) begin
      start6_q     <= start_d;
      leap_cur6_q  <= is_leap(y5_q);
      leap_prev6_q <= is_leap(y5_q - 8'd1);
      wday6_q      <= wday_full[2:0];
      y6_q         <= y5_q;
      days6_q      <= days5_q;
    end
    if (en[7]) begin
      year7_q <= back_year ? (y6_q - 8'd1) : y6_q;
      yday7_q <= back_year ? yday_back[8:0] : yday_diff[8:0];
      leap7_q <= back_year ? leap_prev6_q : leap_cur6_q;
      wday7_q <= wday6_q;
    end
    if (en[8]) begin
      month8_q <= month_d;
      yday8_q  <= yday7_q;
      leap8_q  <= leap7_q;
      year8_q  <= year7_q;
      wday8_q  <= wday7_q;
    end
    if (en[9]) begin
      sec9_q   <= sec8;
      min9_q   <= min8;
      hour9_q  <= hour8;
      dom9_q   <= dom_full[4:0];
      month9_q <= month8_q;
      year9_q  <= year8_q + YearBase;
      wday9_q  <= wday8_q;
      yday9_q  <= yday8_q;
    end
  end

  assign tod_en = '{s8: en[8], s7: en[7], s6: en[6], s5: en[5]};

  s2c_time_of_day u_tod (
    .clk_i    (clk_i),
    .en_i     (tod_en),
    .dsec_i   (dsec4_q),
    .hour_o   (hour8),
    .minute_o (min8),
    .second_o (sec8)
  );

  assign dom_unused_pad = '0;

  assign m_axis_tdata_o = {2'b00, yday9_q, wday9_q, year9_q, month9_q,
                           dom9_q | dom_unused_pad, hour9_q, min9_q, sec9_q};

  `S2C_ASSERT_NEXT(a_accept_lands, s_axis_tvalid_i && s_axis_tready_o, v_q[1], "accepted transfer missing from first stage")
  `S2C_ASSERT_IMPLIES(a_ready_chain, m_axis_tready_i, s_axis_tready_o, "pipe stalled with receiver ready")
  `S2C_ASSERT_IMPLIES(a_day_split, v_q[4], dsec4_q < SecsPerDay, "seconds of day out of range")
  `S2C_ASSERT_IMPLIES(a_year_fix, v_q[8], (yday8_q < DaysPerYear) || (leap8_q && (yday8_q == DaysPerYear)), "day of year beyond year length")
  `S2C_ASSERT_IMPLIES(a_date_range, v_q[9], (month9_q < NumMonths) && (dom9_q != 5'd0), "month or day of month out of range")

endmodule

>>> verif/tb_top.sv
module tb_top;
  import s2c_pkg::*;

  // Days per month in a common year; February grows by one in a leap year.
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned NumPhases    = 5;
  localparam int unsigned RandPerPhase = 160;
  localparam int unsigned DrainCycles  = 20;   // well past the depth of the pipe

  // Calendar result, laid out as on m_axis_tdata_o.
  typedef struct packed {
    logic [1:0] pad;
    logic [8:0] day_of_year;
    logic [2:0] weekday;
    logic [7:0] year_since_1900;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } calendar_t;

  // Counts placed on calendar edges, read with a zero zone offset.
  localparam logic [31:0] EdgeCounts [14] = '{
    32'd0,           // 2000-01-01 00:00:00, Saturday
    32'd86399,       // last second of the first day
    32'd86400,
    32'd5097599,     // 2000-02-28 23:59:59
    32'd5097600,     // 2000-02-29, leap day
    32'd5184000,     // 2000-03-01
    32'd31536000,    // 2000-12-31, day of year 365
    32'd31622400,    // 2001-01-01
    32'd131328000,   // 2004-02-29
    32'd3155759999,  // 2099-12-31 23:59:59
    32'd3155760000,  // 2100-01-01
    32'd3160771200,  // 2100-02-28, century year without a leap day
    32'd3160857600,  // 2100-03-01
    32'hAAAA_AAAA
  };

  class calendar_scoreboard;
    logic [15:0] zone_offset;
    calendar_t   pending_dates [$];
    int unsigned mismatches;
    int unsigned compared;

    function new();
      zone_offset = ZoneOffsetReset;
      mismatches  = 0;
      compared    = 0;
    endfunction

    function calendar_t to_calendar(logic [31:0] count);
      logic [31:0] local_secs;
      logic [31:0] days;
      logic [31:0] day_secs;
      int unsigned yr;
      int unsigned mo;
      int unsigned ylen;
      int unsigned mlen;
      logic        leap;
      calendar_t   r;
      local_secs = count + {16'd0, zone_offset};  // wraps modulo 2^32
      days       = local_secs / 86400;
      day_secs   = local_secs % 86400;
      r          = '0;
      r.second   = 6'(day_secs % 60);
      r.minute   = 6'((day_secs / 60) % 60);
      r.hour     = 5'(day_secs / 3600);
      r.weekday  = 3'((days + 6) % 7);
      yr = 0;
      forever begin
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        ylen = leap ? 366 : 365;
        if (days < ylen) break;
        days = days - ylen;
        yr++;
      end
      r.day_of_year = 9'(days);
      mo = 0;
      while (mo < 11) begin
        mlen = MonthDays[mo] + ((mo == 1 && leap) ? 1 : 0);
        if (days < mlen) break;
        days = days - mlen;
        mo++;
      end
      r.day_of_month    = 5'(days + 1);
      r.month           = 4'(mo);
      r.year_since_1900 = 8'(yr + 100);
      return r;
    endfunction

    function void note_input(logic [31:0] count);
      pending_dates.push_back(to_calendar(count));
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        $error("calendar result %h arrived with no conversion pending", got);
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      compared++;
      if (got.second !== want.second) begin
        $error("second: expected %0d, actual %0d", want.second, got.second);
        mismatches++;
      end
      if (got.minute !== want.minute) begin
        $error("minute: expected %0d, actual %0d", want.minute, got.minute);
        mismatches++;
      end
      if (got.hour !== want.hour) begin
        $error("hour: expected %0d, actual %0d", want.hour, got.hour);
        mismatches++;
      end
      if (got.day_of_month !== want.day_of_month) begin
        $error("day_of_month: expected %0d, actual %0d", want.day_of_month, got.day_of_month);
        mismatches++;
      end
      if (got.month !== want.month) begin
        $error("month: expected %0d, actual %0d", want.month, got.month);
        mismatches++;
      end
      if (got.year_since_1900 !== want.year_since_1900) begin
        $error("year_since_1900: expected %0d, actual %0d",
               want.year_since_1900, got.year_since_1900);
        mismatches++;
      end
      if (got.weekday !== want.weekday) begin
        $error("weekday: expected %0d, actual %0d", want.weekday, got.weekday);
        mismatches++;
      end
      if (got.day_of_year !== want.day_of_year) begin
        $error("day_of_year: expected %0d, actual %0d", want.day_of_year, got.day_of_year);
        mismatches++;
      end
      if (got.pad !== want.pad) begin
        $error("pad: expected %0d, actual %0d", want.pad, got.pad);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_count = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        steady = 1'b0;   // no idling on either side while set
  logic        s_ready;
  logic        m_valid;
  logic [47:0] m_data;
  int unsigned counts_sent = 0;

  calendar_scoreboard dates;

  seconds_to_calendar u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_count),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the receiver with a chance of about 6 in 100, except while steady is set.
  always @(posedge clk) begin
    m_ready <= steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (rst_n && dates != null) begin
      if (s_valid && s_ready) begin
        dates.note_input(s_count);
      end
      if (m_valid && m_ready) begin
        dates.check_result(calendar_t'(m_data));
      end
    end
  end

  task automatic send_count(logic [31:0] count);
    if (!steady && $urandom_range(99) < 6) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_count <= count;
    do @(posedge clk); while (!s_ready);
    counts_sent++;
  endtask

  // Let the pipe drain, then load the offset on an idle block.
  task automatic write_zone(logic [15:0] offset);
    s_valid <= 1'b0;
    while (dates.pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= offset;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dates.zone_offset = offset;
  endtask

  function automatic logic [31:0] pick_count(logic [15:0] offset);
    logic [31:0] day_start;
    case ($urandom_range(4))
      0, 1: return $urandom;
      2: begin
        // land near midnight in local time
        day_start = $urandom_range(0, 49709) * 86400;
        return day_start - {16'd0, offset} + ($urandom_range(1) ? 32'd0 : 32'd86399);
      end
      3: return 32'hFFFF_FFFF - $urandom_range(0, 200000);  // wrap region
      default: return $urandom_range(0, 4000000);           // early 2000
    endcase
  endfunction

  initial begin
    logic [15:0] offsets [NumPhases];
    int unsigned p;
    int unsigned i;
    dates = new();
    offsets = '{ZoneOffsetReset, 16'd0, 16'hFFFF, 16'd50400, 16'($urandom)};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (p = 0; p < NumPhases; p++) begin
      // the first phase runs on the offset loaded by reset
      if (p > 0) begin
        write_zone(offsets[p]);
      end
      steady <= (p == 2);
      if (p == 1) begin
        foreach (EdgeCounts[k]) begin
          send_count(EdgeCounts[k]);
        end
      end
      send_count(32'd0);
      send_count(32'hFFFF_FFFF);
      for (i = 0; i < RandPerPhase; i++) begin
        send_count(pick_count(offsets[p]));
      end
    end
    s_valid <= 1'b0;
    steady  <= 1'b0;
    while (dates.pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Converted %0d second counts under %0d zone offsets (0, 28800, 50400, 65535, %0d);",
             counts_sent, NumPhases, offsets[NumPhases - 1]);
    $display("compared %0d calendar results, leap days and counter wrap included.",
             dates.compared);
    if (dates.mismatches == 0 && dates.pending_dates.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/s2c_pkg.sv
hdl/s2c_time_of_day.sv
hdl/seconds_to_calendar.sv
verif/tb_top.sv
